[src/sample_statistics_engine_macros.svh]
`ifndef SAMPLE_STATISTICS_ENGINE_MACROS_SVH
`define SAMPLE_STATISTICS_ENGINE_MACROS_SVH

// same-cycle implication
`define SSE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sse_pkg.sv]
`default_nettype none
package sse_pkg;

  localparam int CAPACITY_DEF  = 1024;
  localparam int TURN_BITS_DEF = 16;

  localparam int SEED_W   = 32;
  localparam int TURNS_W  = 16;
  localparam int GAMES_W  = 11;
  localparam int MED_W    = 17;
  localparam int MEAN_W   = 24;
  localparam int SD_W     = 23;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_OBS,
    OP_SEL_START,
    OP_SCAN,
    OP_SEL_BIT,
    OP_MED_LATCH,
    OP_MUL1_START,
    OP_MUL2_START,
    OP_MUL_STEP,
    OP_DIVM_START,
    OP_DIVV_START,
    OP_DIV_STEP,
    OP_SQRT_START,
    OP_SQRT_STEP,
    OP_RESULT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   second;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic odd;
    logic scan_done;
    logic bit_last;
    logic step_last;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

[src/sse_ctrl.sv]
`default_nettype none
module sse_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire logic                kind,
  output logic                     in_stall,
  output sse_pkg::dp_cmd_t         cmd,
  input  wire sse_pkg::dp_status_t status
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SEL_START,
    S_SCAN,
    S_SEL_BIT,
    S_MED_LATCH,
    S_MUL1_START,
    S_MUL1,
    S_MUL2_START,
    S_MUL2,
    S_DIVM_START,
    S_DIVM,
    S_DIVV_START,
    S_DIVV,
    S_SQRT_START,
    S_SQRT,
    S_RESULT
  } state_t;

  state_t state;
  logic   second;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      second <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid && kind) begin
            second <= 1'b0;
            state  <= status.empty ? S_RESULT : S_SEL_START;
          end
        end
        S_SEL_START: state <= S_SCAN;
        S_SCAN: begin
          if (status.scan_done) state <= S_SEL_BIT;
        end
        S_SEL_BIT: state <= status.bit_last ? S_MED_LATCH : S_SCAN;
        S_MED_LATCH: begin
          if (!status.odd && !second) begin
            second <= 1'b1;
            state  <= S_SEL_START;
          end else begin
            state <= S_MUL1_START;
          end
        end
        S_MUL1_START: state <= S_MUL1;
        S_MUL1: begin
          if (status.step_last) state <= S_MUL2_START;
        end
        S_MUL2_START: state <= S_MUL2;
        S_MUL2: begin
          if (status.step_last) state <= S_DIVM_START;
        end
        S_DIVM_START: state <= S_DIVM;
        S_DIVM: begin
          if (status.step_last) state <= S_DIVV_START;
        end
        S_DIVV_START: state <= S_DIVV;
        S_DIVV: begin
          if (status.step_last) state <= S_SQRT_START;
        end
        S_SQRT_START: state <= S_SQRT;
        S_SQRT: begin
          if (status.step_last) state <= S_RESULT;
        end
        S_RESULT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd.second = second;
    case (state)
      S_IDLE:       cmd.op = (in_valid && !kind) ? sse_pkg::OP_OBS : sse_pkg::OP_NONE;
      S_SEL_START:  cmd.op = sse_pkg::OP_SEL_START;
      S_SCAN:       cmd.op = sse_pkg::OP_SCAN;
      S_SEL_BIT:    cmd.op = sse_pkg::OP_SEL_BIT;
      S_MED_LATCH:  cmd.op = sse_pkg::OP_MED_LATCH;
      S_MUL1_START: cmd.op = sse_pkg::OP_MUL1_START;
      S_MUL1:       cmd.op = sse_pkg::OP_MUL_STEP;
      S_MUL2_START: cmd.op = sse_pkg::OP_MUL2_START;
      S_MUL2:       cmd.op = sse_pkg::OP_MUL_STEP;
      S_DIVM_START: cmd.op = sse_pkg::OP_DIVM_START;
      S_DIVM:       cmd.op = sse_pkg::OP_DIV_STEP;
      S_DIVV_START: cmd.op = sse_pkg::OP_DIVV_START;
      S_DIVV:       cmd.op = sse_pkg::OP_DIV_STEP;
      S_SQRT_START: cmd.op = sse_pkg::OP_SQRT_START;
      S_SQRT:       cmd.op = sse_pkg::OP_SQRT_STEP;
      S_RESULT:     cmd.op = status.out_free ? sse_pkg::OP_RESULT : sse_pkg::OP_NONE;
      default:      cmd.op = sse_pkg::OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

[src/sse_dp.sv]
`default_nettype none
module sse_dp #(
  parameter int CAPACITY  = sse_pkg::CAPACITY_DEF,
  parameter int TURN_BITS = sse_pkg::TURN_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire sse_pkg::dp_cmd_t            cmd,
  output sse_pkg::dp_status_t              status,
  input  wire logic                        cfg_valid,
  input  wire logic [sse_pkg::SEED_W-1:0]  cfg_data,
  input  wire logic [1:0]                  outcome,
  input  wire logic [sse_pkg::TURNS_W-1:0] turns,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sse_pkg::SEED_W-1:0]       seed_echo,
  output logic [sse_pkg::GAMES_W-1:0]      games,
  output logic [sse_pkg::GAMES_W-1:0]      wins_first,
  output logic [sse_pkg::GAMES_W-1:0]      wins_second,
  output logic [sse_pkg::GAMES_W-1:0]      tie_count,
  output logic [sse_pkg::TURNS_W-1:0]      shortest_turns,
  output logic [sse_pkg::TURNS_W-1:0]      longest_turns,
  output logic [sse_pkg::MED_W-1:0]        median_x2,
  output logic [sse_pkg::MEAN_W-1:0]       mean_q8,
  output logic [sse_pkg::SD_W-1:0]         stddev_q8,
  output logic                             empty_res,
  output logic                             overflow
);

  localparam int GAMES_W = sse_pkg::GAMES_W;
  localparam int TURNS_W = sse_pkg::TURNS_W;
  localparam int MED_W   = sse_pkg::MED_W;
  localparam int MEAN_W  = sse_pkg::MEAN_W;
  localparam int SD_W    = sse_pkg::SD_W;
  localparam int TW      = TURN_BITS;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int SUM_W   = TW + CNT_W;
  localparam int SQ_W    = 2 * TW + CNT_W;
  localparam int D_W     = 2 * TW + 2 * CNT_W;
  localparam int DV_W    = D_W + 16;
  localparam int DVS_W   = 2 * CNT_W;
  localparam int R       = (DV_W + 1) / 2;
  localparam int SX_W    = 2 * R;
  localparam int CT_W    = $clog2(DV_W + 1);

  logic [TW-1:0] mem [CAPACITY];

  logic [31:0]      seed;
  logic [CNT_W-1:0] game_count, first_wins, second_wins, ties_seen;
  logic [SUM_W-1:0] turn_sum;
  logic [SQ_W-1:0]  turn_square_sum;
  logic [TW-1:0]    min_seen, max_seen;
  logic             dropped_flag;

  logic [CNT_W-1:0] idx, sel_k, sel_c;
  logic             rd_vld;
  logic [TW-1:0]    rd_data, prefix, hi_mask, bsel;
  logic [TW:0]      med_acc;

  logic [D_W-1:0]   acc, mcand;
  logic [SUM_W-1:0] mplr;
  logic             sub;
  logic [DV_W-1:0]  dq;
  logic [DVS_W-1:0] dvs, dv_rem;
  logic [SX_W-1:0]  sx;
  logic [R+1:0]     sq_rem;
  logic [R-1:0]     root;
  logic [CT_W-1:0]  cnt;
  logic [MEAN_W-1:0] mean_r;

  logic [TW-1:0]    t_in;
  logic [2*TW-1:0]  t_sq;
  logic [DVS_W-1:0] n_sq;
  logic             full;
  logic             hit;
  logic [DVS_W:0]   dv_sh;
  logic             dv_ge;
  logic [R+3:0]     sq_sh, sq_trial;
  logic             sq_ge;

  assign t_in = TW'(turns);
  assign t_sq = (2*TW)'(t_in) * (2*TW)'(t_in);
  assign n_sq = DVS_W'(game_count) * DVS_W'(game_count);
  assign full = (game_count >= CNT_W'(CAPACITY));
  assign hit  = (((rd_data ^ prefix) & hi_mask) == '0) && ((rd_data & bsel) == '0);

  assign dv_sh = {dv_rem, dq[DV_W-1]};
  assign dv_ge = (dv_sh >= {1'b0, dvs});

  assign sq_sh    = {sq_rem, sx[SX_W-1:SX_W-2]};
  assign sq_trial = (R+4)'({root, 2'b01});
  assign sq_ge    = (sq_sh >= sq_trial);

  assign status.empty     = (game_count == '0);
  assign status.odd       = game_count[0];
  assign status.scan_done = (idx == game_count) && !rd_vld;
  assign status.bit_last  = bsel[0];
  assign status.step_last = (cnt == CT_W'(1));
  assign status.out_free  = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.op == sse_pkg::OP_OBS && !full) begin
      mem[game_count[ADDR_W-1:0]] <= t_in;
    end
    rd_data <= mem[idx[ADDR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed            <= '0;
      game_count      <= '0;
      first_wins      <= '0;
      second_wins     <= '0;
      ties_seen       <= '0;
      turn_sum        <= '0;
      turn_square_sum <= '0;
      min_seen        <= '1;
      max_seen        <= '0;
      dropped_flag    <= 1'b0;
      out_valid       <= 1'b0;
      rd_vld          <= 1'b0;
    end else begin
      if (cfg_valid) seed <= cfg_data;
      if (cmd.op == sse_pkg::OP_RESULT) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (cmd.op)
        sse_pkg::OP_OBS: begin
          if (full) begin
            dropped_flag <= 1'b1;
          end else begin
            if (outcome[1])      first_wins  <= first_wins + 1'b1;
            else if (outcome[0]) second_wins <= second_wins + 1'b1;
            else                 ties_seen   <= ties_seen + 1'b1;
            game_count      <= game_count + 1'b1;
            turn_sum        <= turn_sum + SUM_W'(t_in);
            turn_square_sum <= turn_square_sum + SQ_W'(t_sq);
            if (t_in < min_seen) min_seen <= t_in;
            if (t_in > max_seen) max_seen <= t_in;
          end
        end
        sse_pkg::OP_SEL_START: rd_vld <= 1'b0;
        sse_pkg::OP_SCAN:      rd_vld <= (idx != game_count);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      sse_pkg::OP_SEL_START: begin
        idx     <= '0;
        sel_c   <= '0;
        prefix  <= '0;
        hi_mask <= '0;
        bsel    <= {1'b1, {(TW-1){1'b0}}};
        if (cmd.second || game_count[0]) sel_k <= game_count >> 1;
        else                             sel_k <= (game_count >> 1) - 1'b1;
        if (!cmd.second) med_acc <= '0;
      end
      sse_pkg::OP_SCAN: begin
        if (idx != game_count) idx <= idx + 1'b1;
        if (rd_vld && hit) sel_c <= sel_c + 1'b1;
      end
      sse_pkg::OP_SEL_BIT: begin
        if (sel_k >= sel_c) begin
          sel_k  <= sel_k - sel_c;
          prefix <= prefix | bsel;
        end
        hi_mask <= hi_mask | bsel;
        bsel    <= bsel >> 1;
        idx     <= '0;
        sel_c   <= '0;
      end
      sse_pkg::OP_MED_LATCH: begin
        if (game_count[0]) med_acc <= med_acc + {prefix, 1'b0};
        else               med_acc <= med_acc + (TW+1)'(prefix);
      end
      sse_pkg::OP_MUL1_START: begin
        acc   <= '0;
        mplr  <= SUM_W'(game_count);
        mcand <= D_W'(turn_square_sum);
        sub   <= 1'b0;
        cnt   <= CT_W'(CNT_W);
      end
      sse_pkg::OP_MUL2_START: begin
        mplr  <= turn_sum;
        mcand <= D_W'(turn_sum);
        sub   <= 1'b1;
        cnt   <= CT_W'(SUM_W);
      end
      sse_pkg::OP_MUL_STEP: begin
        if (mplr[0]) acc <= sub ? acc - mcand : acc + mcand;
        mplr  <= mplr >> 1;
        mcand <= mcand << 1;
        cnt   <= cnt - 1'b1;
      end
      sse_pkg::OP_DIVM_START: begin
        dq     <= DV_W'(turn_sum) << 8;
        dvs    <= DVS_W'(game_count);
        dv_rem <= '0;
        cnt    <= CT_W'(DV_W);
      end
      sse_pkg::OP_DIVV_START: begin
        mean_r <= MEAN_W'(dq);
        dq     <= DV_W'(acc) << 16;
        dvs    <= n_sq;
        dv_rem <= '0;
        cnt    <= CT_W'(DV_W);
      end
      sse_pkg::OP_DIV_STEP: begin
        dv_rem <= dv_ge ? DVS_W'(dv_sh - {1'b0, dvs}) : DVS_W'(dv_sh);
        dq     <= {dq[DV_W-2:0], dv_ge};
        cnt    <= cnt - 1'b1;
      end
      sse_pkg::OP_SQRT_START: begin
        sx     <= SX_W'(dq);
        sq_rem <= '0;
        root   <= '0;
        cnt    <= CT_W'(R);
      end
      sse_pkg::OP_SQRT_STEP: begin
        sq_rem <= sq_ge ? (R+2)'(sq_sh - sq_trial) : (R+2)'(sq_sh);
        root   <= {root[R-2:0], sq_ge};
        sx     <= sx << 2;
        cnt    <= cnt - 1'b1;
      end
      sse_pkg::OP_RESULT: begin
        seed_echo   <= seed;
        games       <= GAMES_W'(game_count);
        wins_first  <= GAMES_W'(first_wins);
        wins_second <= GAMES_W'(second_wins);
        tie_count   <= GAMES_W'(ties_seen);
        overflow    <= dropped_flag;
        empty_res   <= (game_count == '0);
        if (game_count == '0) begin
          shortest_turns <= '0;
          longest_turns  <= '0;
          median_x2      <= '0;
          mean_q8        <= '0;
          stddev_q8      <= '0;
        end else begin
          shortest_turns <= TURNS_W'(min_seen);
          longest_turns  <= TURNS_W'(max_seen);
          median_x2      <= MED_W'(med_acc);
          mean_q8        <= mean_r;
          stddev_q8      <= SD_W'(root);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

[src/sample_statistics_engine.sv]
`default_nettype none
// Game statistics collector. An observation transaction (kind 0) is taken while idle and
// updates the tallies, running sums, extremes and the turn-count memory; once the memory
// holds CAPACITY entries further observations are dropped and the overflow flag is set.
// A report transaction (kind 1) walks the memory to select the median bit by bit: each of
// the TURN_BITS passes reads n entries through the single memory read port, and an even
// count needs two elements. Then a shift-add multiplier forms n*sumsq - sum^2, a restoring
// divider gives the mean and the variance, and a digit-by-digit square root gives the
// deviation. No input is taken until the report has been loaded into the output register.
// An empty store reports immediately. cfg_ready is always high; the seed register is
// echoed in every report.
module sample_statistics_engine #(
  parameter int CAPACITY  = sse_pkg::CAPACITY_DEF,
  parameter int TURN_BITS = sse_pkg::TURN_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [sse_pkg::SEED_W-1:0]  cfg_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [1:0]                  outcome,
  input  wire logic [sse_pkg::TURNS_W-1:0] turns,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [sse_pkg::SEED_W-1:0]       seed_echo,
  output logic [sse_pkg::GAMES_W-1:0]      games,
  output logic [sse_pkg::GAMES_W-1:0]      wins_first,
  output logic [sse_pkg::GAMES_W-1:0]      wins_second,
  output logic [sse_pkg::GAMES_W-1:0]      tie_count,
  output logic [sse_pkg::TURNS_W-1:0]      shortest_turns,
  output logic [sse_pkg::TURNS_W-1:0]      longest_turns,
  output logic [sse_pkg::MED_W-1:0]        median_x2,
  output logic [sse_pkg::MEAN_W-1:0]       mean_q8,
  output logic [sse_pkg::SD_W-1:0]         stddev_q8,
  output logic                             empty_res,
  output logic                             overflow
);

  `include "sample_statistics_engine_macros.svh"

  sse_pkg::dp_cmd_t    cmd;
  sse_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  sse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .kind     (kind),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  sse_dp #(
    .CAPACITY  (CAPACITY),
    .TURN_BITS (TURN_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .outcome        (outcome),
    .turns          (turns),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .seed_echo      (seed_echo),
    .games          (games),
    .wins_first     (wins_first),
    .wins_second    (wins_second),
    .tie_count      (tie_count),
    .shortest_turns (shortest_turns),
    .longest_turns  (longest_turns),
    .median_x2      (median_x2),
    .mean_q8        (mean_q8),
    .stddev_q8      (stddev_q8),
    .empty_res      (empty_res),
    .overflow       (overflow)
  );

  // a report transaction holds off the input from the cycle after it is accepted
  `SSE_ASSERT_NEXT(a_report_busy, in_valid && !in_stall && kind, in_stall, "report not busy")
  // observation updates only on an accepted transaction
  `SSE_ASSERT_SAME(a_obs_accept, cmd.op == sse_pkg::OP_OBS,
                   in_valid && !in_stall && !kind, "observation without transaction")
  // empty report carries zero statistics
  `SSE_ASSERT_SAME(a_empty_zero, out_valid && empty_res,
                   mean_q8 == '0 && stddev_q8 == '0 && median_x2 == '0, "empty report not zero")

endmodule
`default_nettype wire

[verif/sample_statistics_engine_tb.sv]
`default_nettype none

typedef struct packed {
  logic [31:0] seed_echo;
  logic [10:0] games;
  logic [10:0] wins_first;
  logic [10:0] wins_second;
  logic [10:0] tie_count;
  logic [15:0] shortest_turns;
  logic [15:0] longest_turns;
  logic [16:0] median_x2;
  logic [23:0] mean_q8;
  logic [22:0] stddev_q8;
  logic        empty_res;
  logic        overflow;
} game_report_t;

class stats_scoreboard;
  localparam int STORE_DEPTH = sse_pkg::CAPACITY_DEF;

  bit [31:0]       seed;
  bit [15:0]       turn_log[$];
  int unsigned     first_wins, second_wins, ties;
  longint unsigned turn_sum, square_sum;
  bit [15:0]       min_seen, max_seen;
  bit              dropped;
  game_report_t    report_q[$];
  int              errors;

  function new();
    seed = '0;
    first_wins = 0;
    second_wins = 0;
    ties = 0;
    turn_sum = 0;
    square_sum = 0;
    min_seen = '1;
    max_seen = '0;
    dropped = 1'b0;
    errors = 0;
  endfunction

  function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned probe;
    root = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function void note_input(bit is_report, bit [1:0] oc, bit [15:0] t);
    game_report_t    r;
    bit [15:0]       sorted[$];
    longint unsigned n, nn, d, q, rem;
    if (!is_report) begin
      if (turn_log.size() >= STORE_DEPTH) begin
        dropped = 1'b1;
        return;
      end
      if (oc[1]) first_wins++;
      else if (oc == 2'b01) second_wins++;
      else ties++;
      turn_log.insert(turn_log.size(), t);
      turn_sum += t;
      square_sum += longint'(t) * t;
      if (t < min_seen) min_seen = t;
      if (t > max_seen) max_seen = t;
      return;
    end
    n = turn_log.size();
    r = '0;
    r.seed_echo = seed;
    r.games = n[10:0];
    r.wins_first = first_wins[10:0];
    r.wins_second = second_wins[10:0];
    r.tie_count = ties[10:0];
    r.empty_res = (n == 0);
    r.overflow = dropped;
    if (n != 0) begin
      sorted = turn_log;
      sorted.sort();
      r.shortest_turns = min_seen;
      r.longest_turns = max_seen;
      if (n % 2 == 1) r.median_x2 = {sorted[n / 2], 1'b0};
      else r.median_x2 = 17'(sorted[n / 2 - 1]) + 17'(sorted[n / 2]);
      r.mean_q8 = 24'((turn_sum * 256) / n);
      nn = n * n;
      d = n * square_sum - turn_sum * turn_sum;
      q = d / nn;
      rem = d % nn;
      r.stddev_q8 = 23'(int_sqrt(q * 65536 + (rem * 65536) / nn));
    end
    report_q.insert(report_q.size(), r);
  endfunction

  function void check_field(string name, longint unsigned exp_v, longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_report(game_report_t got);
    game_report_t e;
    if (report_q.size() == 0) begin
      $display("%0t: unexpected report, expected none actual %p", $time, got);
      errors++;
      return;
    end
    e = report_q.pop_front();
    check_field("seed_echo", e.seed_echo, got.seed_echo);
    check_field("games", e.games, got.games);
    check_field("wins_first", e.wins_first, got.wins_first);
    check_field("wins_second", e.wins_second, got.wins_second);
    check_field("tie_count", e.tie_count, got.tie_count);
    check_field("shortest_turns", e.shortest_turns, got.shortest_turns);
    check_field("longest_turns", e.longest_turns, got.longest_turns);
    check_field("median_x2", e.median_x2, got.median_x2);
    check_field("mean_q8", e.mean_q8, got.mean_q8);
    check_field("stddev_q8", e.stddev_q8, got.stddev_q8);
    check_field("empty_res", e.empty_res, got.empty_res);
    check_field("overflow", e.overflow, got.overflow);
  endfunction
endclass

module sample_statistics_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit       KIND_OBS    = 1'b0;
  localparam bit       KIND_REPORT = 1'b1;
  localparam bit [1:0] OC_TIE      = 2'b00;
  localparam bit [1:0] OC_SECOND   = 2'b01;
  localparam bit [1:0] OC_MINUS2   = 2'b10;
  localparam bit [1:0] OC_FIRST    = 2'b11;
  localparam int       CYCLE_LIMIT = 4000000;
  localparam int       SETTLE      = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        kind = 1'b0;
  logic [1:0]  outcome = '0;
  logic [15:0] turns = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  game_report_t got;

  stats_scoreboard sb = new();
  int  cycles = 0;
  int  stall_left = 0;
  bit  idling_on = 1'b1;

  sample_statistics_engine u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .kind(kind), .outcome(outcome), .turns(turns),
    .out_valid(out_valid), .out_stall(out_stall),
    .seed_echo(got.seed_echo), .games(got.games),
    .wins_first(got.wins_first), .wins_second(got.wins_second),
    .tie_count(got.tie_count), .shortest_turns(got.shortest_turns),
    .longest_turns(got.longest_turns),
    .median_x2(got.median_x2), .mean_q8(got.mean_q8), .stddev_q8(got.stddev_q8),
    .empty_res(got.empty_res), .overflow(got.overflow)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[sample_statistics_engine] ERROR");
      $finish;
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_report(got);
      stall_left = idling_on ? $urandom_range(0, 5) : 0;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_item(bit k, bit [1:0] oc, bit [15:0] t);
    int gap;
    gap = idling_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    outcome = oc;
    turns = t;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_input(k, oc, t);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.report_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_seed(bit [31:0] s);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data = s;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.seed = s;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic random_item();
    int n;
    int pct;
    n = sb.turn_log.size();
    // reports are costly on a big store, so they thin out as it fills
    if (n < 64) pct = 250;
    else if (n < 256) pct = 50;
    else pct = 7;
    if ($urandom_range(0, 999) < pct) send_item(KIND_REPORT, 2'($urandom), 16'($urandom));
    else if ($urandom_range(0, 9) == 0)
      send_item(KIND_OBS, 2'($urandom), $urandom_range(0, 1) ? 16'hffff : 16'h0000);
    else send_item(KIND_OBS, 2'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    write_seed(32'hffff_ffff);
    // empty store report
    send_item(KIND_REPORT, OC_TIE, 16'h0000);
    send_item(KIND_OBS, OC_MINUS2, 16'hffff);
    send_item(KIND_REPORT, OC_FIRST, 16'hffff);
    send_item(KIND_OBS, OC_TIE, 16'h0000);
    send_item(KIND_REPORT, OC_SECOND, 16'h1234);
    send_item(KIND_OBS, OC_SECOND, 16'h0001);
    send_item(KIND_OBS, OC_FIRST, 16'h8000);
    send_item(KIND_REPORT, OC_MINUS2, 16'h0000);
    send_item(KIND_OBS, OC_TIE, 16'h7fff);
    send_item(KIND_OBS, OC_TIE, 16'h7fff);
    send_item(KIND_REPORT, OC_TIE, 16'h0000);
    send_item(KIND_OBS, OC_MINUS2, 16'haaaa);
    send_item(KIND_OBS, OC_SECOND, 16'h5555);
    send_item(KIND_REPORT, OC_TIE, 16'h0000);

    write_seed(32'h0000_0000);
    for (int phase = 0; phase < 4; phase++) begin
      idling_on = (phase != 1);
      for (int i = 0; i < 460; i++) random_item();
      write_seed(phase == 2 ? 32'hffff_ffff : $urandom);
      send_item(KIND_REPORT, OC_TIE, 16'h0000);
    end

    wait_idle();
    if (sb.errors == 0 && sb.report_q.size() == 0)
      $display("[sample_statistics_engine] OK");
    else
      $display("[sample_statistics_engine] ERROR");
    $finish;
  end
endmodule

`default_nettype wire
